[sv/c402dss_pkg.sv]
package c402dss_pkg;

  // Power state of the drive as decoded from its status word.
  typedef enum logic [3:0] {
    ST_START              = 4'd0,
    ST_NOT_READY          = 4'd1,
    ST_SWITCH_ON_DISABLED = 4'd2,
    ST_READY              = 4'd3,
    ST_SWITCHED_ON        = 4'd4,
    ST_OP_ENABLED         = 4'd5,
    ST_QUICK_STOP         = 4'd6,
    ST_FAULT_REACTION     = 4'd7,
    ST_FAULT              = 4'd8,
    ST_UNDEFINED          = 4'd9
  } drive_state_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_TRANSITIONS     = 2'd0,
    CFG_AUTO_FAULT_CLEAR     = 2'd1,
    CFG_RESET_REQUEST_ENABLE = 2'd2
  } cfg_idx_e;

  // Status word masks and patterns.
  localparam logic [15:0] SW_MASK_A        = 16'h004F;
  localparam logic [15:0] SW_MASK_B        = 16'h006F;
  localparam logic [15:0] SW_NOT_READY     = 16'h0000;
  localparam logic [15:0] SW_SWITCH_ON_DIS = 16'h0040;
  localparam logic [15:0] SW_READY         = 16'h0021;
  localparam logic [15:0] SW_SWITCHED_ON   = 16'h0023;
  localparam logic [15:0] SW_OP_ENABLED    = 16'h0027;
  localparam logic [15:0] SW_QUICK_STOP    = 16'h0007;
  localparam logic [15:0] SW_FAULT_REACT   = 16'h000F;
  localparam logic [15:0] SW_FAULT         = 16'h0008;

  // Control word keep masks and forced bits for each rewriting state.
  localparam logic [15:0] CW_KEEP_SHUTDOWN  = 16'h007E;
  localparam logic [15:0] CW_SET_SHUTDOWN   = 16'h0006;
  localparam logic [15:0] CW_KEEP_SWITCH_ON = 16'h0077;
  localparam logic [15:0] CW_SET_SWITCH_ON  = 16'h0007;
  localparam logic [15:0] CW_KEEP_ENABLE    = 16'h007F;
  localparam logic [15:0] CW_SET_ENABLE     = 16'h000F;
  localparam logic [15:0] CW_KEEP_FAULT_RST = 16'h00FF;
  localparam logic [15:0] CW_SET_FAULT_RST  = 16'h0080;

  typedef struct packed {
    logic auto_transitions;
    logic auto_fault_clear;
    logic reset_request_enable;
  } cfg_t;

  typedef struct packed {
    logic [15:0] status_in;
    logic [15:0] command_word_in;
    logic        reset_request;
    logic        link_operational;
  } item_t;

  typedef struct packed {
    drive_state_e state;
    logic [15:0]  prev_status;
    logic         request_seen;
    logic         reset_pending;
  } seq_state_t;

  typedef struct packed {
    logic [15:0]  command_word_out;
    drive_state_e drive_state;
    logic         state_changed;
    logic         drive_ready;
  } result_t;

endpackage

[sv/c402dss_in_if.sv]
interface c402dss_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] status_in;
  logic [15:0] command_word_in;
  logic        reset_request;
  logic        link_operational;

  modport source (
    output valid, status_in, command_word_in, reset_request, link_operational,
    input  ready
  );
  modport sink (
    input  valid, status_in, command_word_in, reset_request, link_operational,
    output ready
  );
endinterface

[sv/c402dss_out_if.sv]
interface c402dss_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] command_word_out;
  logic [3:0]  drive_state;
  logic        state_changed;
  logic        drive_ready;

  modport source (
    output valid, command_word_out, drive_state, state_changed, drive_ready,
    input  ready
  );
  modport sink (
    input  valid, command_word_out, drive_state, state_changed, drive_ready,
    output ready
  );
endinterface

[sv/c402dss_step.sv]
// One fieldbus cycle of the sequencer: request edge detection, control word
// rewrite from the stored state, and status word decode.
module c402dss_step (
  input  c402dss_pkg::cfg_t       cfg_i,
  input  c402dss_pkg::seq_state_t state_i,
  input  c402dss_pkg::item_t      item_i,
  output c402dss_pkg::seq_state_t state_o,
  output c402dss_pkg::result_t    result_o
);

  function automatic c402dss_pkg::drive_state_e decode_status(input logic [15:0] sw);
    logic [15:0] a;
    logic [15:0] b;
    a = sw & c402dss_pkg::SW_MASK_A;
    b = sw & c402dss_pkg::SW_MASK_B;
    if (a == c402dss_pkg::SW_NOT_READY)          return c402dss_pkg::ST_NOT_READY;
    else if (a == c402dss_pkg::SW_SWITCH_ON_DIS) return c402dss_pkg::ST_SWITCH_ON_DISABLED;
    else if (b == c402dss_pkg::SW_READY)         return c402dss_pkg::ST_READY;
    else if (b == c402dss_pkg::SW_SWITCHED_ON)   return c402dss_pkg::ST_SWITCHED_ON;
    else if (b == c402dss_pkg::SW_OP_ENABLED)    return c402dss_pkg::ST_OP_ENABLED;
    else if (b == c402dss_pkg::SW_QUICK_STOP)    return c402dss_pkg::ST_QUICK_STOP;
    else if (a == c402dss_pkg::SW_FAULT_REACT)   return c402dss_pkg::ST_FAULT_REACTION;
    else if (a == c402dss_pkg::SW_FAULT)         return c402dss_pkg::ST_FAULT;
    else                                         return c402dss_pkg::ST_UNDEFINED;
  endfunction

  logic                       seen;
  logic                       pending;
  logic [15:0]                cw;
  c402dss_pkg::drive_state_e  next_state;

  // Reset request edge detection and control word rewrite.
  always_comb begin
    seen    = state_i.request_seen;
    pending = state_i.reset_pending;
    cw      = item_i.command_word_in;
    if (item_i.link_operational && cfg_i.reset_request_enable) begin
      if (!item_i.reset_request) begin
        seen = 1'b0;
      end else if (!seen) begin
        seen    = 1'b1;
        pending = 1'b1;
      end
    end
    if (item_i.link_operational && cfg_i.auto_transitions) begin
      unique case (state_i.state) inside
        c402dss_pkg::ST_SWITCH_ON_DISABLED: begin
          cw = (cw & c402dss_pkg::CW_KEEP_SHUTDOWN) | c402dss_pkg::CW_SET_SHUTDOWN;
        end
        c402dss_pkg::ST_READY: begin
          cw = (cw & c402dss_pkg::CW_KEEP_SWITCH_ON) | c402dss_pkg::CW_SET_SWITCH_ON;
        end
        c402dss_pkg::ST_SWITCHED_ON, c402dss_pkg::ST_QUICK_STOP: begin
          cw = (cw & c402dss_pkg::CW_KEEP_ENABLE) | c402dss_pkg::CW_SET_ENABLE;
        end
        c402dss_pkg::ST_FAULT: begin
          // A fault reset consumes the pending request.
          if (cfg_i.auto_fault_clear || pending) begin
            pending = 1'b0;
            cw      = (cw & c402dss_pkg::CW_KEEP_FAULT_RST) | c402dss_pkg::CW_SET_FAULT_RST;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Decode only when the status word has moved; otherwise hold the state.
  always_comb begin
    if (item_i.status_in != state_i.prev_status) begin
      next_state = decode_status(item_i.status_in);
    end else begin
      next_state = state_i.state;
    end
  end

  // The stored state is also the previous cycle's state.
  always_comb begin
    state_o.state          = next_state;
    state_o.prev_status    = item_i.status_in;
    state_o.request_seen   = seen;
    state_o.reset_pending  = pending;
    result_o.command_word_out = cw;
    result_o.drive_state      = next_state;
    result_o.state_changed    = (next_state != state_i.state);
    result_o.drive_ready      = (next_state == c402dss_pkg::ST_OP_ENABLED) &&
                                (state_i.state == c402dss_pkg::ST_OP_ENABLED);
  end

endmodule

[sv/cia402_drive_state_sequencer_top.sv]
// CiA402 drive state sequencer. Each input transaction is one fieldbus cycle;
// one transaction is taken per clock while the result register is free, and
// each yields exactly one result transaction through the input register and
// the result register around the single decode and rewrite pass. The sequencer
// state (decoded drive state, last status word, reset request edge and pending
// fault reset) is updated as each item leaves the input register, so items
// follow one another without gaps. Configuration writes take effect on the
// next clock edge and are expected only while no transaction is in flight.
module cia402_drive_state_sequencer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [c402dss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic                                cfg_data_i,
  c402dss_in_if.sink                          in_i,
  c402dss_out_if.source                       out_o
);

  c402dss_pkg::cfg_t       cfg_q, cfg_d;
  c402dss_pkg::item_t      item_q;
  logic                    item_vld_q;
  c402dss_pkg::seq_state_t seq_q, seq_d;
  c402dss_pkg::result_t    res_q, res_d;
  logic                    out_vld_q;
  logic                    advance;
  logic                    fire;
  logic                    in_fire;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (c402dss_pkg::cfg_idx_e'(cfg_idx_i))
        c402dss_pkg::CFG_AUTO_TRANSITIONS:     cfg_d.auto_transitions     = cfg_data_i;
        c402dss_pkg::CFG_AUTO_FAULT_CLEAR:     cfg_d.auto_fault_clear     = cfg_data_i;
        c402dss_pkg::CFG_RESET_REQUEST_ENABLE: cfg_d.reset_request_enable = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Handshake: the result register frees whenever it is empty or taken.
  assign advance    = !out_vld_q || out_o.ready;
  assign fire       = item_vld_q && advance;
  assign in_i.ready = !item_vld_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.status_in        <= in_i.status_in;
      item_q.command_word_in  <= in_i.command_word_in;
      item_q.reset_request    <= in_i.reset_request;
      item_q.link_operational <= in_i.link_operational;
    end
  end

  c402dss_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (seq_q),
    .item_i   (item_q),
    .state_o  (seq_d),
    .result_o (res_d)
  );

  // Sequencer state moves on as an item is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q.state         <= c402dss_pkg::ST_START;
      seq_q.prev_status   <= '0;
      seq_q.request_seen  <= 1'b0;
      seq_q.reset_pending <= 1'b0;
    end else if (fire) begin
      seq_q <= seq_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.command_word_out = res_q.command_word_out;
  assign out_o.drive_state      = 4'(res_q.drive_state);
  assign out_o.state_changed    = res_q.state_changed;
  assign out_o.drive_ready      = res_q.drive_ready;

  // Ready is only reported while operation enabled is the decoded state.
  a_ready_in_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.drive_ready |-> res_q.drive_state == c402dss_pkg::ST_OP_ENABLED)
    else $error("drive_ready outside operation enabled");

  // A fault reset issued from the fault state leaves nothing pending.
  a_reset_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item_q.link_operational && cfg_q.auto_transitions &&
    seq_q.state == c402dss_pkg::ST_FAULT |=> !seq_q.reset_pending)
    else $error("pending fault reset not consumed");

  // An unchanged status word holds the decoded state.
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item_q.status_in == seq_q.prev_status |=> seq_q.state == $past(seq_q.state))
    else $error("state moved on an unchanged status word");

  // With the link down the control word passes unchanged.
  a_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !item_q.link_operational |=>
      res_q.command_word_out == $past(item_q.command_word_in))
    else $error("control word rewritten while link is down");

endmodule

[tb/cia402_drive_state_sequencer_top_test.sv]
`timescale 1ns / 1ps

module cia402_drive_state_sequencer_top_test;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [c402dss_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned CYCLES_PER_PHASE = 250;
  localparam int unsigned HOLD_OFF_CYCLES = 80;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i = 1'b0;
  logic [c402dss_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic                              cfg_data_i = 1'b0;

  c402dss_in_if  in_if ();
  c402dss_out_if out_if ();

  cia402_drive_state_sequencer_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Fieldbus cycles waiting to be offered, and the results they must produce.
  c402dss_pkg::item_t   pending_cycles_q[$];
  c402dss_pkg::result_t expected_drive_q[$];

  // Shadow copy of the sequencer state and its settings.
  c402dss_pkg::seq_state_t seq_model = '0;
  c402dss_pkg::cfg_t       cfg_model = '0;

  int unsigned mismatches = 0;
  bit          gaps_on = 1'b1;
  int unsigned hold_requests = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Safety net against a stalled handshake.
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Maps a status word onto a power state by masked pattern compare.
  function automatic c402dss_pkg::drive_state_e decode_status_word(logic [15:0] sw);
    logic [15:0] low_a;
    logic [15:0] low_b;
    low_a = sw & c402dss_pkg::SW_MASK_A;
    low_b = sw & c402dss_pkg::SW_MASK_B;
    if (low_a == c402dss_pkg::SW_NOT_READY)     return c402dss_pkg::ST_NOT_READY;
    if (low_a == c402dss_pkg::SW_SWITCH_ON_DIS) return c402dss_pkg::ST_SWITCH_ON_DISABLED;
    if (low_b == c402dss_pkg::SW_READY)         return c402dss_pkg::ST_READY;
    if (low_b == c402dss_pkg::SW_SWITCHED_ON)   return c402dss_pkg::ST_SWITCHED_ON;
    if (low_b == c402dss_pkg::SW_OP_ENABLED)    return c402dss_pkg::ST_OP_ENABLED;
    if (low_b == c402dss_pkg::SW_QUICK_STOP)    return c402dss_pkg::ST_QUICK_STOP;
    if (low_a == c402dss_pkg::SW_FAULT_REACT)   return c402dss_pkg::ST_FAULT_REACTION;
    if (low_a == c402dss_pkg::SW_FAULT)         return c402dss_pkg::ST_FAULT;
    return c402dss_pkg::ST_UNDEFINED;
  endfunction

  // Advances the shadow sequencer by one fieldbus cycle and returns its result.
  function automatic c402dss_pkg::result_t sequence_cycle(c402dss_pkg::item_t cyc);
    c402dss_pkg::result_t      res;
    logic [15:0]               word;
    c402dss_pkg::drive_state_e next_st;
    word = cyc.command_word_in;
    if (cyc.link_operational) begin
      // A rising request level latches a fault reset.
      if (cfg_model.reset_request_enable) begin
        if (!cyc.reset_request) begin
          seq_model.request_seen = 1'b0;
        end else if (!seq_model.request_seen) begin
          seq_model.request_seen  = 1'b1;
          seq_model.reset_pending = 1'b1;
        end
      end
      // The rewrite follows the state decoded in the previous cycle.
      if (cfg_model.auto_transitions) begin
        case (seq_model.state) inside
          c402dss_pkg::ST_SWITCH_ON_DISABLED:
            word = (word & c402dss_pkg::CW_KEEP_SHUTDOWN) | c402dss_pkg::CW_SET_SHUTDOWN;
          c402dss_pkg::ST_READY:
            word = (word & c402dss_pkg::CW_KEEP_SWITCH_ON) | c402dss_pkg::CW_SET_SWITCH_ON;
          c402dss_pkg::ST_SWITCHED_ON, c402dss_pkg::ST_QUICK_STOP:
            word = (word & c402dss_pkg::CW_KEEP_ENABLE) | c402dss_pkg::CW_SET_ENABLE;
          c402dss_pkg::ST_FAULT: begin
            if (cfg_model.auto_fault_clear || seq_model.reset_pending) begin
              seq_model.reset_pending = 1'b0;
              word = (word & c402dss_pkg::CW_KEEP_FAULT_RST) | c402dss_pkg::CW_SET_FAULT_RST;
            end
          end
          default: ;
        endcase
      end
    end
    // An unchanged status word keeps the state as it is.
    next_st = seq_model.state;
    if (cyc.status_in != seq_model.prev_status) begin
      next_st = decode_status_word(cyc.status_in);
    end
    res.command_word_out = word;
    res.drive_state      = next_st;
    res.state_changed    = (next_st != seq_model.state);
    res.drive_ready      = (next_st == c402dss_pkg::ST_OP_ENABLED) &&
                           (seq_model.state == c402dss_pkg::ST_OP_ENABLED);
    seq_model.state       = next_st;
    seq_model.prev_status = cyc.status_in;
    return res;
  endfunction

  // Random status word that decodes to the given state.
  function automatic logic [15:0] status_word_for(c402dss_pkg::drive_state_e st);
    logic [15:0] w;
    w = 16'($urandom);
    case (st)
      c402dss_pkg::ST_NOT_READY:
        w = (w & ~c402dss_pkg::SW_MASK_A) | c402dss_pkg::SW_NOT_READY;
      c402dss_pkg::ST_SWITCH_ON_DISABLED:
        w = (w & ~c402dss_pkg::SW_MASK_A) | c402dss_pkg::SW_SWITCH_ON_DIS;
      c402dss_pkg::ST_READY:
        w = (w & ~c402dss_pkg::SW_MASK_B) | c402dss_pkg::SW_READY;
      c402dss_pkg::ST_SWITCHED_ON:
        w = (w & ~c402dss_pkg::SW_MASK_B) | c402dss_pkg::SW_SWITCHED_ON;
      c402dss_pkg::ST_OP_ENABLED:
        w = (w & ~c402dss_pkg::SW_MASK_B) | c402dss_pkg::SW_OP_ENABLED;
      c402dss_pkg::ST_QUICK_STOP:
        w = (w & ~c402dss_pkg::SW_MASK_B) | c402dss_pkg::SW_QUICK_STOP;
      c402dss_pkg::ST_FAULT_REACTION:
        w = (w & ~c402dss_pkg::SW_MASK_A) | c402dss_pkg::SW_FAULT_REACT;
      c402dss_pkg::ST_FAULT:
        w = (w & ~c402dss_pkg::SW_MASK_A) | c402dss_pkg::SW_FAULT;
      c402dss_pkg::ST_UNDEFINED: begin
        while (decode_status_word(w) != c402dss_pkg::ST_UNDEFINED) w = 16'($urandom);
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic push_cycle(logic [15:0] status, logic [15:0] word, logic req, logic link);
    c402dss_pkg::item_t cyc;
    cyc.status_in        = status;
    cyc.command_word_in  = word;
    cyc.reset_request    = req;
    cyc.link_operational = link;
    pending_cycles_q = {pending_cycles_q, cyc};
  endtask

  // A drive walking the power state machine, with occasional jumps, repeated
  // status words, request edges and link drops.
  task automatic queue_drive_session(int unsigned count);
    c402dss_pkg::drive_state_e walk;
    int unsigned               dwell;
    logic [15:0]               status;
    logic                      req;
    walk   = c402dss_pkg::ST_NOT_READY;
    dwell  = $urandom_range(1, 5);
    status = status_word_for(walk);
    req    = 1'b0;
    repeat (count) begin
      if (dwell == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          walk = c402dss_pkg::drive_state_e'($urandom_range(c402dss_pkg::ST_NOT_READY,
                                                            c402dss_pkg::ST_UNDEFINED));
        end else begin
          case (walk)
            c402dss_pkg::ST_NOT_READY:          walk = c402dss_pkg::ST_SWITCH_ON_DISABLED;
            c402dss_pkg::ST_SWITCH_ON_DISABLED: walk = c402dss_pkg::ST_READY;
            c402dss_pkg::ST_READY:              walk = c402dss_pkg::ST_SWITCHED_ON;
            c402dss_pkg::ST_SWITCHED_ON:        walk = c402dss_pkg::ST_OP_ENABLED;
            c402dss_pkg::ST_OP_ENABLED: begin
              case ($urandom_range(0, 3))
                0:       walk = c402dss_pkg::ST_FAULT_REACTION;
                1:       walk = c402dss_pkg::ST_QUICK_STOP;
                2:       walk = c402dss_pkg::ST_SWITCH_ON_DISABLED;
                default: walk = c402dss_pkg::ST_READY;
              endcase
            end
            c402dss_pkg::ST_QUICK_STOP:         walk = c402dss_pkg::ST_SWITCH_ON_DISABLED;
            c402dss_pkg::ST_FAULT_REACTION:     walk = c402dss_pkg::ST_FAULT;
            c402dss_pkg::ST_FAULT:              walk = c402dss_pkg::ST_SWITCH_ON_DISABLED;
            default:                            walk = c402dss_pkg::ST_NOT_READY;
          endcase
        end
        dwell  = $urandom_range(1, 5);
        status = status_word_for(walk);
      end else if ($urandom_range(0, 3) != 0) begin
        status = status_word_for(walk);
      end
      dwell--;
      if ($urandom_range(0, 4) == 0) req = ~req;
      push_cycle(status, 16'($urandom), req, $urandom_range(0, 9) != 0);
    end
  endtask

  task automatic write_register(logic [c402dss_pkg::CFG_IDX_W-1:0] idx, logic value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      c402dss_pkg::CFG_AUTO_TRANSITIONS:     cfg_model.auto_transitions = value;
      c402dss_pkg::CFG_AUTO_FAULT_CLEAR:     cfg_model.auto_fault_clear = value;
      c402dss_pkg::CFG_RESET_REQUEST_ENABLE: cfg_model.reset_request_enable = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(c402dss_pkg::cfg_t s);
    write_register(c402dss_pkg::CFG_AUTO_TRANSITIONS, s.auto_transitions);
    write_register(c402dss_pkg::CFG_AUTO_FAULT_CLEAR, s.auto_fault_clear);
    write_register(c402dss_pkg::CFG_RESET_REQUEST_ENABLE, s.reset_request_enable);
    @(negedge clk_i);
  endtask

  // Returns once every queued cycle has been taken and answered.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_cycles_q.size() != 0 || in_if.valid || expected_drive_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Stimulus: reset, directed cycles, then random phases under varied settings.
  initial begin : stimulus
    c402dss_pkg::cfg_t pick;
    rst_ni = 1'b0;
    in_if.valid            = 1'b0;
    in_if.status_in        = '0;
    in_if.command_word_in  = '0;
    in_if.reset_request    = 1'b0;
    in_if.link_operational = 1'b0;
    out_if.ready           = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: the control word passes untouched.
    push_cycle(16'h0000, 16'hFFFF, 1'b0, 1'b1);  // zero status keeps the start state
    push_cycle(16'hFFFF, 16'h0000, 1'b1, 1'b1);  // matches no pattern
    push_cycle(16'hFFFF, 16'hA5A5, 1'b0, 1'b0);  // unchanged status word
    for (int s = c402dss_pkg::ST_NOT_READY; s <= c402dss_pkg::ST_FAULT; s++) begin
      push_cycle(status_word_for(c402dss_pkg::drive_state_e'(s)), 16'hFFFF, s[0], 1'b1);
    end
    wait_idle();

    // Rewriting on, fault reset only through the request input.
    write_register(CFG_IDX_UNUSED, 1'b1);
    pick = '{auto_transitions: 1'b1, auto_fault_clear: 1'b0, reset_request_enable: 1'b1};
    apply_settings(pick);
    push_cycle(status_word_for(c402dss_pkg::ST_FAULT), 16'hFFFF, 1'b0, 1'b1);
    // Request edge, so the reset is issued.
    push_cycle(status_word_for(c402dss_pkg::ST_FAULT), 16'hFFFF, 1'b1, 1'b1);
    // Level held, so nothing is pending.
    push_cycle(status_word_for(c402dss_pkg::ST_FAULT), 16'hFFFF, 1'b1, 1'b1);
    // Link down.
    push_cycle(status_word_for(c402dss_pkg::ST_SWITCH_ON_DISABLED), 16'hFFFF, 1'b0, 1'b0);
    push_cycle(status_word_for(c402dss_pkg::ST_SWITCH_ON_DISABLED), 16'hFFFF, 1'b1, 1'b1);
    push_cycle(status_word_for(c402dss_pkg::ST_READY), 16'h0000, 1'b0, 1'b1);
    push_cycle(status_word_for(c402dss_pkg::ST_SWITCHED_ON), 16'hFFFF, 1'b0, 1'b1);
    push_cycle(status_word_for(c402dss_pkg::ST_OP_ENABLED), 16'h0000, 1'b0, 1'b1);
    push_cycle(status_word_for(c402dss_pkg::ST_OP_ENABLED), 16'hFFFF, 1'b0, 1'b1);
    push_cycle(status_word_for(c402dss_pkg::ST_QUICK_STOP), 16'h0000, 1'b0, 1'b1);
    push_cycle(status_word_for(c402dss_pkg::ST_FAULT_REACTION), 16'h0000, 1'b0, 1'b1);
    // Latched here, not yet used.
    push_cycle(status_word_for(c402dss_pkg::ST_FAULT), 16'hFFFF, 1'b1, 1'b1);
    push_cycle(status_word_for(c402dss_pkg::ST_UNDEFINED), 16'hFFFF, 1'b1, 1'b1);
    push_cycle(status_word_for(c402dss_pkg::ST_NOT_READY), 16'hFFFF, 1'b0, 1'b1);
    wait_idle();

    // Random phases; the first two use the extreme settings.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) pick = '1;
      else if (p == 1) pick = '0;
      else pick = c402dss_pkg::cfg_t'(3'($urandom_range(0, 7)));
      apply_settings(pick);
      if (p == RANDOM_PHASES - 1) gaps_on = 1'b0;
      queue_drive_session(CYCLES_PER_PHASE);
      if (p == 2) begin
        @(negedge clk_i);
        hold_requests++;
      end
      wait_idle();
    end

    repeat (10) @(negedge clk_i);
    if (expected_drive_q.size() != 0) begin
      report_mismatch("results never delivered", 16'(expected_drive_q.size()), 16'h0);
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Driver: offers queued cycles, predicting each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin : cycle_driver
    c402dss_pkg::item_t offered;
    c402dss_pkg::item_t next_cyc;
    int unsigned        send_gap;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      offered = {in_if.status_in, in_if.command_word_in,
                 in_if.reset_request, in_if.link_operational};
      if (in_if.valid && in_if.ready) begin
        expected_drive_q = {expected_drive_q, sequence_cycle(offered)};
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 9);
          in_if.valid <= 1'b0;
        end else if (pending_cycles_q.size() != 0) begin
          next_cyc = pending_cycles_q.pop_front();
          in_if.valid            <= 1'b1;
          in_if.status_in        <= next_cyc.status_in;
          in_if.command_word_in  <= next_cyc.command_word_in;
          in_if.reset_request    <= next_cyc.reset_request;
          in_if.link_operational <= next_cyc.link_operational;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and applies back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    c402dss_pkg::result_t want;
    int unsigned          stall_left;
    int unsigned          hold_left;
    int unsigned          hold_served;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left  = 0;
      hold_left   = 0;
      hold_served = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_drive_q.size() == 0) begin
          report_mismatch("unexpected result, control word", out_if.command_word_out, 16'h0);
        end else begin
          want = expected_drive_q.pop_front();
          if (out_if.command_word_out !== want.command_word_out) begin
            report_mismatch("command_word_out", out_if.command_word_out, want.command_word_out);
          end
          if (out_if.drive_state !== want.drive_state) begin
            report_mismatch("drive_state", 16'(out_if.drive_state), 16'(want.drive_state));
          end
          if (out_if.state_changed !== want.state_changed) begin
            report_mismatch("state_changed", 16'(out_if.state_changed), 16'(want.state_changed));
          end
          if (out_if.drive_ready !== want.drive_ready) begin
            report_mismatch("drive_ready", 16'(out_if.drive_ready), 16'(want.drive_ready));
          end
        end
      end
      // A long hold-off lets the block fill up and stall its input.
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_OFF_CYCLES;
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

endmodule

[cia402_drive_state_sequencer_top.f]
sv/c402dss_pkg.sv
sv/c402dss_in_if.sv
sv/c402dss_out_if.sv
sv/c402dss_step.sv
sv/cia402_drive_state_sequencer_top.sv
tb/cia402_drive_state_sequencer_top_test.sv
